[sv/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_seq, uer_dist and ultrasonic_echo_ranger; no dependencies.
package uer_pkg;

  // Measurement phases of the ranging sequencer.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRIG  = 2'd1,
    PH_RISE  = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_TICKS = 1'd0,
    REG_WAIT_LIMIT    = 1'd1
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned TRIG_W     = 8;

  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd25;
  localparam logic [TICK_W-1:0] WAIT_LIMIT_RST    = 16'd30000;

  // Distance = count * (340 / 2) / 10000, reduced to count * 17 / 1000.
  localparam int unsigned SPEED_HALF = 340 / 2;
  localparam int unsigned SCALE_DIV  = 10000;
  localparam int unsigned DIST_MUL   = SPEED_HALF / 10;
  localparam int unsigned DIST_DIV   = SCALE_DIV / 10;

  localparam int unsigned DIST_W   = 11;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;

  // Products at or above this value saturate the distance.
  localparam int unsigned DIST_SAT_PROD = (DIST_MAX + 1) * DIST_DIV;

  // floor(p / 1000) = (p * RECIP_DIV) >> RECIP_SHIFT for p < 2^21.
  localparam int unsigned RECIP_SHIFT = 31;
  localparam int unsigned RECIP_DIV   = 2147484;
  localparam int unsigned PROD_W      = 21;

  // Digit split: floor(d / 10) and floor(d / 100) by reciprocal for d < 2048.
  localparam int unsigned RECIP10     = 3277;
  localparam int unsigned RECIP10_SH  = 15;
  localparam int unsigned RECIP100    = 1311;
  localparam int unsigned RECIP100_SH = 17;

  // Per-tick status that travels along the result pipeline.
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic timed_out;
  } res_flags_t;

endpackage

[sv/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: configuration registers,
// stream ports, sequencer and result pipeline. Depends on uer_pkg,
// uer_seq and uer_dist.
//
// Every input transaction is one microsecond tick and produces exactly one
// result transaction. The sequencer updates on the accepting edge, so a new
// tick can be taken every cycle while in_tready is high. The result leaves
// through a four-stage pipeline (count, scale multiply, reciprocal divide
// by 1000, digit split) whose last stage is the output register. in_tready
// falls only when that pipeline is full and out_tready is low. cfg_ready is
// always high; registers are meant to be written while the block is idle.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [0] start_req, [1] echo, [7:2] zero.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  // out_tdata: [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
  // [14:4] distance_cm, [18:15] digit_meters, [22:19] digit_decimeters,
  // [26:23] digit_centimeters, [31:27] zero.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import uer_pkg::*;

  logic [TRIG_W-1:0] trig_ticks_r;
  logic [TICK_W-1:0] wait_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= TRIGGER_TICKS_RST;
      wait_limit_r <= WAIT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIGGER_TICKS: trig_ticks_r <= cfg_data[TRIG_W-1:0];
        REG_WAIT_LIMIT:    wait_limit_r <= cfg_data[TICK_W-1:0];
      endcase
    end
  end

  logic                  tick;
  res_flags_t            seq_flags;
  logic [COUNT_BITS-1:0] seq_count;

  assign tick = in_tvalid && in_tready;

  uer_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (tick),
    .start_req    (in_tdata[0]),
    .echo         (in_tdata[1]),
    .trigger_ticks(trig_ticks_r),
    .wait_limit   (wait_limit_r),
    .flags        (seq_flags),
    .count        (seq_count)
  );

  res_flags_t         res_flags;
  logic [DIST_W-1:0]  res_dist;
  logic [DIGIT_W-1:0] res_m, res_dm, res_cm;

  uer_dist #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dist (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_flags       (seq_flags),
    .in_count       (seq_count),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_flags      (res_flags),
    .out_dist       (res_dist),
    .out_meters     (res_m),
    .out_decimeters (res_dm),
    .out_centimeters(res_cm)
  );

  assign out_tdata = {5'd0, res_cm, res_dm, res_m, res_dist,
                      res_flags.timed_out, res_flags.done,
                      res_flags.busy, res_flags.trigger};

endmodule

[sv/uer_seq.sv]
// Ranging sequencer: trigger pulse, echo rise wait and echo high count.
// Depends on uer_pkg; advances one tick per accepted input transaction.
module uer_seq #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  logic                           start_req,
  input  logic                           echo,
  input  logic [uer_pkg::TRIG_W-1:0]     trigger_ticks,
  input  logic [uer_pkg::TICK_W-1:0]     wait_limit,
  output uer_pkg::res_flags_t            flags,
  output logic [COUNT_BITS-1:0]          count
);
  import uer_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                tseen_r, tseen_nxt;
  logic [TICK_W-1:0]   ticks_inc;
  logic                done;

  assign ticks_inc = ticks_r + TICK_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    cnt_nxt   = cnt_r;
    tseen_nxt = tseen_r;
    done      = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          phase_nxt = PH_TRIG;
          ticks_nxt = '0;
          cnt_nxt   = '0;
          tseen_nxt = 1'b0;
        end
      end
      PH_TRIG: begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= TICK_W'(trigger_ticks)) begin
          phase_nxt = PH_RISE;
          ticks_nxt = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          phase_nxt = PH_COUNT;
          ticks_nxt = '0;
          cnt_nxt   = '0;
        end else begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= wait_limit) begin
            tseen_nxt = 1'b1;
            phase_nxt = PH_COUNT;
            ticks_nxt = '0;
            cnt_nxt   = '0;
          end
        end
      end
      PH_COUNT: begin
        if (echo) begin
          // The count saturates at all ones.
          if (cnt_r != {COUNT_BITS{1'b1}}) begin
            cnt_nxt = cnt_r + COUNT_BITS'(1);
          end
          ticks_nxt = ticks_inc;
          if (ticks_inc >= wait_limit) begin
            tseen_nxt = 1'b1;
            done      = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
        if (done) begin
          phase_nxt = PH_IDLE;
          ticks_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      cnt_r   <= '0;
      tseen_r <= 1'b0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      cnt_r   <= cnt_nxt;
      tseen_r <= tseen_nxt;
    end
  end

  assign flags.trigger   = (phase_nxt == PH_TRIG);
  assign flags.busy      = (phase_nxt != PH_IDLE);
  assign flags.done      = done;
  assign flags.timed_out = done & tseen_nxt;
  // Zero count on non-completing ticks gives zero distance and digits.
  assign count = done ? cnt_nxt : '0;

endmodule

[sv/uer_dist.sv]
// Result pipeline: count register, scale multiply, divide by reciprocal,
// decimal digit split and output register. Depends on uer_pkg.
module uer_dist #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  uer_pkg::res_flags_t              in_flags,
  input  logic [COUNT_BITS-1:0]            in_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output uer_pkg::res_flags_t              out_flags,
  output logic [uer_pkg::DIST_W-1:0]       out_dist,
  output logic [uer_pkg::DIGIT_W-1:0]      out_meters,
  output logic [uer_pkg::DIGIT_W-1:0]      out_decimeters,
  output logic [uer_pkg::DIGIT_W-1:0]      out_centimeters
);
  import uer_pkg::*;

  localparam int unsigned PW = COUNT_BITS + 5;
  localparam int unsigned CW = (PW > PROD_W + 1) ? PW : PROD_W + 1;
  localparam int unsigned RW = PROD_W + 22;

  // Stage valids and per-stage advance.
  logic v1_r, v2_r, v3_r, v4_r;
  logic go1, go2, go3, go4;

  res_flags_t            f1_r, f2_r, f3_r, f4_r;
  logic [COUNT_BITS-1:0] cnt1_r;
  logic [PW-1:0]         prod2_r;
  logic [DIST_W-1:0]     dist3_r, dist4_r;
  logic [DIGIT_W-1:0]    dm4_r, dd4_r, dc4_r;

  assign go4      = !v4_r || out_ready;
  assign go3      = !v3_r || go4;
  assign go2      = !v2_r || go3;
  assign go1      = !v1_r || go2;
  assign in_ready = go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go1) v1_r <= in_valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
    end
  end

  // Stage 2 input: count * 17.
  logic [PW-1:0] prod_nxt;
  assign prod_nxt = (PW'(cnt1_r) << 4) + PW'(cnt1_r);

  // Stage 3 input: saturate or divide by 1000 through the reciprocal.
  logic [CW-1:0]     prod_ext;
  logic              sat;
  logic [RW-1:0]     recip_prod;
  logic [DIST_W-1:0] dist_nxt;

  assign prod_ext   = CW'(prod2_r);
  assign sat        = prod_ext >= CW'(DIST_SAT_PROD);
  assign recip_prod = RW'(prod_ext[PROD_W-1:0]) * RW'(RECIP_DIV);
  assign dist_nxt   = sat ? DIST_W'(DIST_MAX)
                          : recip_prod[RECIP_SHIFT +: DIST_W];

  // Stage 4 input: decimal digits of the distance.
  logic [DIST_W+12-1:0] m10;
  logic [DIST_W+11-1:0] m100;
  logic [7:0]           q10;
  logic [4:0]           q100;
  logic [DIGIT_W-1:0]   dm_nxt, dd_nxt, dc_nxt;
  logic [7:0]           tens_full;
  logic [DIST_W-1:0]    units_full;

  assign m10        = (DIST_W + 12)'(dist3_r) * (DIST_W + 12)'(RECIP10);
  assign m100       = (DIST_W + 11)'(dist3_r) * (DIST_W + 11)'(RECIP100);
  assign q10        = m10[RECIP10_SH +: 8];
  assign q100       = m100[RECIP100_SH +: 5];
  assign tens_full  = q10 - (8'(q100) * 8'd10);
  assign units_full = dist3_r - DIST_W'(11'(q10) * 11'd10);
  assign dd_nxt     = tens_full[DIGIT_W-1:0];
  assign dc_nxt     = units_full[DIGIT_W-1:0];

  always_comb begin
    if (q100 >= 5'd20) begin
      dm_nxt = DIGIT_W'(q100 - 5'd20);
    end else if (q100 >= 5'd10) begin
      dm_nxt = DIGIT_W'(q100 - 5'd10);
    end else begin
      dm_nxt = DIGIT_W'(q100);
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      f1_r   <= in_flags;
      cnt1_r <= in_count;
    end
    if (go2) begin
      f2_r    <= f1_r;
      prod2_r <= prod_nxt;
    end
    if (go3) begin
      f3_r    <= f2_r;
      dist3_r <= dist_nxt;
    end
    if (go4) begin
      f4_r    <= f3_r;
      dist4_r <= dist3_r;
      dm4_r   <= dm_nxt;
      dd4_r   <= dd_nxt;
      dc4_r   <= dc_nxt;
    end
  end

  assign out_valid       = v4_r;
  assign out_flags       = f4_r;
  assign out_dist        = dist4_r;
  assign out_meters      = dm4_r;
  assign out_decimeters  = dd4_r;
  assign out_centimeters = dc4_r;

endmodule

[tb/sv/ultrasonic_echo_ranger_tb.sv]
// Self-checking testbench for ultrasonic_echo_ranger: per-tick prediction of the
// ranging sequence, checked against every result transaction. Depends on uer_pkg
// and the RTL of the block.
module ultrasonic_echo_ranger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam int unsigned HALF_SOUND_SPEED = 170;
  localparam int unsigned TICK_SCALE       = 10000;
  localparam int unsigned DIST_CAP         = 2047;
  localparam int unsigned QUIET_LIMIT      = 2000;
  localparam int unsigned RANDOM_TICKS     = 300;

  typedef struct packed {
    logic        trigger;
    logic        busy;
    logic        done;
    logic        timed_out;
    logic [10:0] dist_cm;
    logic [3:0]  dig_m;
    logic [3:0]  dig_dm;
    logic [3:0]  dig_cm;
  } range_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted sequencer state and register copies.
  phase_t      ph;
  logic [15:0] ph_ticks;
  logic [15:0] echo_cnt;
  logic        tout_seen;
  logic [7:0]  trig_len;
  logic [15:0] echo_timeout;

  range_result_t range_exp_q[$];
  bit          no_idle;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned n_ticks, n_done, n_tout, n_cfg, n_results, mismatches;

  ultrasonic_echo_ranger i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Advances the predicted sequencer by one tick and returns the result it yields.
  function automatic range_result_t advance_ranger(logic start, logic echo);
    range_result_t r;
    logic          fin;
    int unsigned   prod, d;
    r = '0;
    fin = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (start) begin
          ph = PH_TRIG;
          ph_ticks = '0;
          echo_cnt = '0;
          tout_seen = 1'b0;
        end
      end
      PH_TRIG: begin
        ph_ticks = ph_ticks + 16'd1;
        if (ph_ticks >= {8'd0, trig_len}) begin
          ph = PH_RISE;
          ph_ticks = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          ph = PH_COUNT;
          ph_ticks = '0;
          echo_cnt = '0;
        end else begin
          ph_ticks = ph_ticks + 16'd1;
          if (ph_ticks >= echo_timeout) begin
            tout_seen = 1'b1;
            ph = PH_COUNT;
            ph_ticks = '0;
            echo_cnt = '0;
          end
        end
      end
      default: begin
        if (echo) begin
          if (echo_cnt != 16'hFFFF) echo_cnt = echo_cnt + 16'd1;
          ph_ticks = ph_ticks + 16'd1;
          if (ph_ticks >= echo_timeout) begin
            tout_seen = 1'b1;
            fin = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
        if (fin) begin
          prod = (echo_cnt * HALF_SOUND_SPEED) / TICK_SCALE;
          d = (prod > DIST_CAP) ? DIST_CAP : prod;
          r.timed_out = tout_seen;
          r.dist_cm = d[10:0];
          r.dig_m = 4'((d / 100) % 10);
          r.dig_dm = 4'((d / 10) % 10);
          r.dig_cm = 4'(d % 10);
          ph = PH_IDLE;
          ph_ticks = '0;
        end
      end
    endcase
    r.trigger = (ph == PH_TRIG);
    r.busy = (ph != PH_IDLE);
    r.done = fin;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Sends one tick and predicts its result at the accepting edge.
  task automatic send_tick(logic start, logic echo);
    int unsigned gap;
    range_result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, echo, start};
    do @(posedge clk); while (!in_tready);
    r = advance_ranger(start, echo);
    range_exp_q.push_back(r);
    n_ticks++;
    if (r.done) n_done++;
    if (r.done && r.timed_out) n_tout++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (range_exp_q.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back; only called with the sequencer idle.
  task automatic write_settings(logic [15:0] trig_word, logic [15:0] wait_word);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_data <= trig_word;
    do @(posedge clk); while (!cfg_ready);
    trig_len = trig_word[7:0];
    cfg_index <= REG_WAIT_LIMIT;
    cfg_data <= wait_word;
    do @(posedge clk); while (!cfg_ready);
    echo_timeout = wait_word;
    cfg_valid <= 1'b0;
    n_cfg += 2;
  endtask

  task automatic idle_ticks(int unsigned n);
    repeat (n) send_tick(1'b0, 1'($urandom));
  endtask

  // One measurement from idle back to idle. Echo rises after rise_after ticks
  // of the rise wait and then stays high for high_for ticks of the count phase.
  task automatic run_measurement(int unsigned rise_after, int unsigned high_for,
                                 int unsigned start_pct);
    int unsigned rise_cnt, high_cnt;
    logic e;
    rise_cnt = 0;
    high_cnt = 0;
    send_tick(1'b1, 1'($urandom));
    while (ph != PH_IDLE) begin
      case (ph)
        PH_TRIG: e = 1'($urandom);
        PH_RISE: begin
          e = (rise_cnt >= rise_after);
          rise_cnt++;
        end
        default: begin
          e = (high_cnt < high_for);
          high_cnt++;
        end
      endcase
      send_tick($urandom_range(0, 99) < start_pct, e);
    end
  endtask

  task automatic test_default_settings();
    idle_ticks(4);
    run_measurement(3, 60, 0);
    idle_ticks(2);
  endtask

  // Shortest, longest and unit trigger pulses; the echo lengths put the
  // distance on both sides of a digit boundary.
  task automatic test_trigger_lengths();
    write_settings(16'd0, 16'd30000);
    run_measurement(0, 589, 0);
    write_settings(16'd255, 16'd30000);
    run_measurement(1, 3, 0);
    write_settings(16'd1, 16'd30000);
    run_measurement(2, 58, 0);
  endtask

  // Start held high through the whole measurement, completing tick included.
  task automatic test_start_while_busy();
    write_settings(16'd3, 16'd40);
    run_measurement(2, 20, 100);
    run_measurement(50, 0, 100);
  endtask

  task automatic test_wait_timeouts();
    write_settings(16'd2, 16'd0);
    run_measurement(1000, 0, 0);
    run_measurement(0, 5, 0);
    write_settings(16'd2, 16'd7);
    run_measurement(100, 0, 0);
    run_measurement(100, 3, 0);
    run_measurement(0, 50, 0);
    run_measurement(0, 7, 0);
    run_measurement(0, 6, 0);
  endtask

  // Largest wait limit; echo falls long before the count phase could time out.
  task automatic test_largest_limit();
    write_settings(16'd1, 16'hFFFF);
    no_idle = 1'b1;
    run_measurement(0, 20, 0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_ranging();
    int unsigned stop_at, meas, r, rise_after, high_for;
    logic [7:0]  trig;
    logic [15:0] wl;
    stop_at = n_ticks + RANDOM_TICKS;
    meas = 0;
    while (n_ticks < stop_at) begin
      if (meas % 6 == 0) begin
        r = $urandom_range(0, 9);
        trig = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 8));
        r = $urandom_range(0, 19);
        wl = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom) :
             16'($urandom_range(1, 60));
        write_settings({8'($urandom), trig}, wl);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 4));
      rise_after = $urandom_range(0, 12);
      high_for = $urandom_range(0, 40);
      if (echo_timeout <= 200) begin
        if ($urandom_range(0, 99) < 15) rise_after = 1000;
        if ($urandom_range(0, 99) < 15) high_for = 1000;
      end
      run_measurement(rise_after, high_for, ($urandom_range(0, 2) == 0) ? 30 : 0);
      meas++;
    end
    no_idle = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    range_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (range_exp_q.size() == 0) begin
        $error("result transaction with no tick waiting for it");
        mismatches++;
      end else begin
        e = range_exp_q.pop_front();
        check_field("trigger", e.trigger, out_tdata[0]);
        check_field("busy_res", e.busy, out_tdata[1]);
        check_field("done_res", e.done, out_tdata[2]);
        check_field("timed_out", e.timed_out, out_tdata[3]);
        check_field("distance_cm", e.dist_cm, out_tdata[14:4]);
        check_field("digit_meters", e.dig_m, out_tdata[18:15]);
        check_field("digit_decimeters", e.dig_dm, out_tdata[22:19]);
        check_field("digit_centimeters", e.dig_cm, out_tdata[26:23]);
      end
    end
  end

  // Receiver stalls: mostly ready, occasional stalls of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_data <= '0;
    stall_left = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    ph = PH_IDLE;
    ph_ticks = '0;
    echo_cnt = '0;
    tout_seen = 1'b0;
    trig_len = TRIGGER_TICKS_RST;
    echo_timeout = WAIT_LIMIT_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_trigger_lengths();
    test_start_while_busy();
    test_wait_timeouts();
    test_largest_limit();
    test_random_ranging();

    wait_drained();
    repeat (8) @(posedge clk);
    if (range_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", range_exp_q.size());
      mismatches++;
    end
    $display("Ran %0d ticks and %0d register writes; %0d measurements completed, %0d timed out.",
             n_ticks, n_cfg, n_done, n_tout);
    $display("Checked %0d result transactions, %0d mismatches.", n_results, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/uer_pkg.sv
sv/uer_seq.sv
sv/uer_dist.sv
sv/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_tb.sv
